/* design/upvfd_pkg.sv */
// Package for the unary-prefixed variable-length field decoder.
// Holds the sizing constants, register indexes, status codes and the item types.
// Has no dependencies; every other file of the block imports it.
package upvfd_pkg;

  // Sizing
  localparam int TABLE_ENTRIES = 8;
  localparam int MAX_BITS      = 4096;
  localparam int FIELD_MAX     = 32;
  localparam int K_W           = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int WINDOW_W  = 64;
  localparam int POS_W     = 12;
  localparam int TLEN_W    = 13;
  localparam int LIMIT_W   = 4;
  localparam int TABLE_W   = 48;
  localparam int ENTRY_W   = 6;
  localparam int VALUE_W   = 32;
  localparam int PBITS_W   = 4;
  localparam int TBITS_W   = 6;
  localparam int SUM_W     = 14;

  // Stream packing
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 48;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Register indexes (byte address / 8)
  localparam logic REG_PREFIX_LIMIT = 1'b0;
  localparam logic REG_LENGTH_TABLE = 1'b1;

  localparam logic [LIMIT_W-1:0] PREFIX_LIMIT_RST = LIMIT_W'(8);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [TABLE_W-1:0] length_table;
    logic [LIMIT_W-1:0] prefix_limit;
  } cfg_t;

  typedef struct packed {
    logic [TLEN_W-1:0]   total_len;
    logic [POS_W-1:0]    start_pos;
    logic [WINDOW_W-1:0] window;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [TBITS_W-1:0] total_bits;
    logic [PBITS_W-1:0] prefix_bits;
    logic [VALUE_W-1:0] value;
  } result_t;

endpackage

/* design/unary_prefix_varlen_field_decode_core.sv */
// Top level of the unary-prefixed variable-length field decoder.
// Depends on upvfd_pkg, upvfd_cfg_regs and upvfd_decode.
//
// Decodes one header field per transaction. An input transaction carries a
// 64-bit MSB-first window starting at the read position, the position and the
// string length; the block counts leading ones (up to prefix_limit, at most
// eight), looks the field length up in length_table and returns the field
// right-aligned with status, prefix and total bit counts. Throughput is one
// transaction per cycle while results are taken, through an input register,
// one pass through the decode logic, and a result register. Both registers
// advance whenever the result register is empty or being taken. While a
// result waits, the input register can still take one transaction, and then
// s_tready stays low until the waiting result is taken. The user writes the
// configuration over the APB port at byte address 0 (prefix_limit) and 8
// (length_table) only while idle; the block itself does not enforce this.
module unary_prefix_varlen_field_decode_core (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: window[63:0], start_pos[75:64], total_len[88:76], zero pad
  input  logic [upvfd_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: value[31:0], prefix_bits[35:32], total_bits[41:36], zero pad
  output logic [upvfd_pkg::M_TDATA_W-1:0]   m_tdata,
  // tuser: status[1:0]
  output logic [1:0]                        m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [upvfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [upvfd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [upvfd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import upvfd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t dec_result;
  result_t out_result;
  logic    out_free;
  logic    in_load;

  upvfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upvfd_decode u_decode (
    .item   (in_item),
    .cfg    (cfg),
    .result (dec_result)
  );

  // Pipeline flow control
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_free;
  assign in_load  = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item <= s_tdata[$bits(item_t)-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid) begin
      out_result <= dec_result;
    end
  end

  assign m_tdata = M_TDATA_W'({out_result.total_bits, out_result.prefix_bits,
                               out_result.value});
  assign m_tuser = out_result.status;

endmodule

/* design/upvfd_cfg_regs.sv */
// APB-style register file for the decoder: prefix limit and length table.
// Depends on upvfd_pkg.
module upvfd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [upvfd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [upvfd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [upvfd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready,
  output upvfd_pkg::cfg_t                    cfg
);
  import upvfd_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes, masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_limit <= PREFIX_LIMIT_RST;
      cfg.length_table <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PREFIX_LIMIT: cfg.prefix_limit <= pwdata[LIMIT_W-1:0];
        REG_LENGTH_TABLE: cfg.length_table <= pwdata[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    unique case (reg_sel)
      REG_PREFIX_LIMIT: prdata = CFG_DATA_W'(cfg.prefix_limit);
      REG_LENGTH_TABLE: prdata = CFG_DATA_W'(cfg.length_table);
      default:          prdata = '0;
    endcase
  end

endmodule

/* design/upvfd_decode.sv */
// Combinational field decode: prefix search, length lookup, bounds check, extract.
// Depends on upvfd_pkg.
module upvfd_decode (
  input  upvfd_pkg::item_t   item,
  input  upvfd_pkg::cfg_t    cfg,
  output upvfd_pkg::result_t result
);
  import upvfd_pkg::*;

  logic [LIMIT_W-1:0]  limit_eff;
  logic [TLEN_W-1:0]   tlen_eff;
  logic [K_W-1:0]      k;
  logic                found;
  logic [ENTRY_W-1:0]  entry;
  logic [ENTRY_W-1:0]  len;
  logic [SUM_W-1:0]    end_sum;
  logic [WINDOW_W-1:0] shifted;
  logic [VALUE_W-1:0]  field;
  logic [PBITS_W-1:0]  pbits;

  // Clamp the search span and the string length
  assign limit_eff = (cfg.prefix_limit > LIMIT_W'(TABLE_ENTRIES)) ?
                     LIMIT_W'(TABLE_ENTRIES) : cfg.prefix_limit;
  assign tlen_eff  = (item.total_len > TLEN_W'(MAX_BITS)) ?
                     TLEN_W'(MAX_BITS) : item.total_len;

  // First zero within the searched span; lowest offset wins
  always_comb begin
    k     = '0;
    found = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((LIMIT_W'(i) < limit_eff) && !item.window[WINDOW_W-1-i]) begin
        k     = K_W'(i);
        found = 1'b1;
      end
    end
  end

  // Length lookup with saturation
  assign entry = cfg.length_table[ENTRY_W*k +: ENTRY_W];
  assign len   = (entry > ENTRY_W'(FIELD_MAX)) ? ENTRY_W'(FIELD_MAX) : entry;

  assign end_sum = SUM_W'(item.start_pos) + SUM_W'(k) + SUM_W'(len);
  assign pbits   = PBITS_W'(k) + PBITS_W'(1);

  // Drop the prefix, then right-align the field
  assign shifted = item.window << (7'(k) + 7'd1);
  assign field   = shifted[WINDOW_W-1 -: VALUE_W] >> (ENTRY_W'(FIELD_MAX) - len);

  always_comb begin
    result.status      = ST_OK;
    result.value       = '0;
    result.prefix_bits = '0;
    result.total_bits  = '0;
    if ((TLEN_W'(item.start_pos) >= tlen_eff) || !found ||
        (end_sum >= SUM_W'(tlen_eff))) begin
      result.status = ST_OOB;
    end else if (len == '0) begin
      result.status      = ST_ZERO;
      result.prefix_bits = pbits;
      result.total_bits  = TBITS_W'(pbits);
    end else begin
      result.value       = field;
      result.prefix_bits = pbits;
      result.total_bits  = TBITS_W'(pbits) + TBITS_W'(len);
    end
  end

endmodule

/* test/tb_unary_prefix_varlen_field_decode_core.sv */
// Testbench for unary_prefix_varlen_field_decode_core: directed and random field decodes,
// checked transaction by transaction against a behavioral decoder kept in this file.
// Depends on upvfd_pkg and the design top level.
`timescale 1ns / 1ps

module tb_unary_prefix_varlen_field_decode_core;
  import upvfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_PREFIX_LIMIT = CFG_ADDR_W'({REG_PREFIX_LIMIT, 3'b000});
  localparam logic [CFG_ADDR_W-1:0] ADDR_LENGTH_TABLE = CFG_ADDR_W'({REG_LENGTH_TABLE, 3'b000});

  logic                  clk;
  logic                  rst;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the configuration registers
  logic [LIMIT_W-1:0] cur_limit;
  logic [TABLE_W-1:0] cur_table;

  result_t pending_decodes[$];
  int      mismatches;
  int      tx_idle_pct;
  int      rx_idle_pct;
  int      rx_hold_req;
  int      rx_hold_left;

  unary_prefix_varlen_field_decode_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Expected decode of one field under the current register settings
  function automatic result_t decode_field(logic [WINDOW_W-1:0] w, logic [POS_W-1:0] p,
                                           logic [TLEN_W-1:0] l);
    result_t r;
    int tlen;
    int lim;
    int k;
    int flen;
    bit found;
    logic [WINDOW_W-1:0] sh;
    r = '0;
    r.status = ST_OOB;
    tlen = int'(l);
    if (tlen > MAX_BITS) tlen = MAX_BITS;
    lim = int'(cur_limit);
    if (lim > TABLE_ENTRIES) lim = TABLE_ENTRIES;
    if (int'(p) >= tlen) return r;
    found = 1'b0;
    k = 0;
    for (int i = 0; i < lim && !found; i++) begin
      if (!w[WINDOW_W-1-i]) begin
        found = 1'b1;
        k = i;
      end
    end
    if (!found) return r;
    flen = int'(cur_table[ENTRY_W*k +: ENTRY_W]);
    if (flen > FIELD_MAX) flen = FIELD_MAX;
    if (int'(p) + k + flen >= tlen) return r;
    r.prefix_bits = PBITS_W'(k + 1);
    r.total_bits  = TBITS_W'(k + 1 + flen);
    if (flen == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    sh = w << (k + 1);
    r.value  = VALUE_W'(sh >> (64 - flen));
    r.status = ST_OK;
    return r;
  endfunction

  // Effective length of table entry k, after saturation
  function automatic int entry_len(int k);
    int flen;
    flen = int'(cur_table[ENTRY_W*k +: ENTRY_W]);
    return (flen > FIELD_MAX) ? FIELD_MAX : flen;
  endfunction

  // Random item: mostly a proper prefix with a length that lands near the string end
  function automatic item_t make_item();
    item_t it;
    int lim;
    int k;
    int need;
    int pos;
    int tlen;
    it.window = {$urandom, $urandom};
    lim = (int'(cur_limit) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cur_limit);
    if (lim > 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, lim - 1);
      for (int i = 0; i < k; i++) it.window[WINDOW_W-1-i] = 1'b1;
      it.window[WINDOW_W-1-k] = 1'b0;
      need = k + entry_len(k);
      pos = $urandom_range(0, 4095 - need);
      // slack 0 puts the last field bit just past the end
      tlen = pos + need + $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) tlen = $urandom_range(0, 8191);
      it.start_pos = POS_W'(pos);
      it.total_len = TLEN_W'(tlen);
    end else begin
      if ($urandom_range(0, 2) == 0) it.window[63:56] = 8'hFF;
      it.start_pos = POS_W'($urandom);
      it.total_len = TLEN_W'($urandom);
    end
    return it;
  endfunction

  // Receiver: random ready, or a long hold-off when one is requested
  initial begin
    m_tready <= 1'b0;
    rx_hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result checker: every output transaction against the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    result_t act_r;
    if (!rst && m_tvalid && m_tready) begin
      act_r.status      = status_t'(m_tuser);
      act_r.value       = m_tdata[31:0];
      act_r.prefix_bits = m_tdata[35:32];
      act_r.total_bits  = m_tdata[41:36];
      if (pending_decodes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d value %h",
                 $time, act_r.status, act_r.value);
        $display("%0t:   actual pb %0d tb %0d", $time, act_r.prefix_bits, act_r.total_bits);
      end else begin
        exp_r = pending_decodes.pop_front();
        if (act_r.status !== exp_r.status || act_r.value !== exp_r.value ||
            act_r.prefix_bits !== exp_r.prefix_bits ||
            act_r.total_bits !== exp_r.total_bits) begin
          mismatches++;
          $display("%0t: mismatch, expected status %0d value %h pb %0d tb %0d,",
                   $time, exp_r.status, exp_r.value, exp_r.prefix_bits, exp_r.total_bits);
          $display("%0t:   actual status %0d value %h pb %0d tb %0d",
                   $time, act_r.status, act_r.value, act_r.prefix_bits, act_r.total_bits);
        end
      end
    end
  end

  // One input transaction, with random idle cycles ahead of it
  task automatic send_item(logic [WINDOW_W-1:0] w, logic [POS_W-1:0] p, logic [TLEN_W-1:0] l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {7'b0, l, p, w};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_decodes.push_back(decode_field(w, p, l));
  endtask

  task automatic send_random(int count);
    item_t it;
    for (int i = 0; i < count; i++) begin
      it = make_item();
      send_item(it.window, it.start_pos, it.total_len);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_PREFIX_LIMIT) cur_limit = data[LIMIT_W-1:0];
    else cur_table = data[TABLE_W-1:0];
  endtask

  // Both registers, written only once the pipeline is empty
  task automatic configure(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] tbl);
    wait_drain();
    apb_write(ADDR_PREFIX_LIMIT, limit);
    apb_write(ADDR_LENGTH_TABLE, tbl);
    @(posedge clk);
  endtask

  function automatic logic [TABLE_W-1:0] rand_table(bit small_entries);
    logic [TABLE_W-1:0] t;
    t = TABLE_W'({$urandom, $urandom});
    if (small_entries)
      for (int i = 0; i < TABLE_ENTRIES; i++)
        t[ENTRY_W*i +: ENTRY_W] = ENTRY_W'($urandom_range(0, 40));
    return t;
  endfunction

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Reset values: limit 8, all lengths zero
  task automatic test_reset_defaults();
    send_item(64'h0123_4567_89AB_CDEF, 12'd0, 13'd4096);
    send_item(64'hF0FF_FFFF_FFFF_FFFF, 12'd20, 13'd100);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 13'd4096);
  endtask

  task automatic test_directed_fields();
    // entries 7..0: 63, 32, 33, 0, 5, 1, 31, 8
    configure(64'd8, {16'hFFFF,
                      6'd63, 6'd32, 6'd33, 6'd0, 6'd5, 6'd1, 6'd31, 6'd8});
    send_item(64'h0123_4567_89AB_CDEF, 12'd0, 13'd4096);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 12'd0, 13'd4096);
    // field ends on the last bit, then one bit past it
    send_item(64'h0, 12'd0, 13'd9);
    send_item(64'h0, 12'd0, 13'd8);
    // zero-length entry
    send_item(64'hF5A5_A5A5_A5A5_A5A5, 12'd3, 13'd200);
    // oversized entries saturate
    send_item(64'hFBFF_FFFF_FFFF_FFFF, 12'd0, 13'd4096);
    send_item(64'hFDAB_CDEF_1234_5678, 12'd0, 13'd4096);
    send_item(64'hFEFF_FFFF_FFFF_FFFF, 12'd4056, 13'd4096);
    send_item(64'hFEFF_FFFF_FFFF_FFFF, 12'd4057, 13'd4096);
    // no terminator within the search span
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 13'd4096);
    send_item(64'hFF00_0000_0000_0000, 12'd0, 13'd4096);
    // position at the end of the string, or on its last bit
    send_item(64'h0, 12'd100, 13'd100);
    send_item(64'h0, 12'd0, 13'd0);
    send_item(64'h0, 12'd4095, 13'd4096);
    // string length above the maximum
    send_item(64'h0, 12'd4095, 13'd8191);
    send_item(64'h3C3C_3C3C_3C3C_3C3C, 12'd10, 13'd5000);
    // search limits: 1, 0, and above the table size
    configure(64'd1, {16'h0, 6'd63, 6'd32, 6'd33, 6'd0, 6'd5, 6'd1, 6'd31, 6'd8});
    send_item(64'h8000_0000_0000_0000, 12'd0, 13'd4096);
    send_item(64'h6000_0000_0000_0000, 12'd0, 13'd4096);
    configure(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(64'h0, 12'd0, 13'd4096);
    configure(64'd15, 64'h0000_FFFF_FFFF_FFFF);
    send_item(64'hFEAA_AAAA_AAAA_AAAA, 12'd0, 13'd4096);
    send_item(64'h5555_5555_5555_5555, 12'd0, 13'd4096);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 13'd4096);
  endtask

  // Random items over a series of register settings and idling patterns
  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] limits[8];
    logic [CFG_DATA_W-1:0] tables[8];
    limits = '{64'd8, 64'd1, 64'd0, 64'd15, 64'd8, 64'd2, 64'd8, 64'd8};
    tables = '{64'h0000_FFFF_FFFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
    limits[4] = CFG_DATA_W'($urandom_range(1, 8));
    limits[5] = CFG_DATA_W'($urandom_range(0, 15));
    tables[1] = CFG_DATA_W'(rand_table(1'b1));
    tables[2] = CFG_DATA_W'(rand_table(1'b0));
    tables[3] = CFG_DATA_W'(rand_table(1'b1));
    tables[4] = CFG_DATA_W'(rand_table(1'b1));
    tables[5] = CFG_DATA_W'(rand_table(1'b0));
    tables[6] = CFG_DATA_W'(rand_table(1'b1));
    tables[7] = CFG_DATA_W'(rand_table(1'b0));
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) set_idling(22, 59);
      else if (ph < 6) set_idling(59, 22);
      else set_idling(0, 0);
      configure(limits[ph], tables[ph]);
      send_random(ph == 2 ? 60 : 210);
    end
  endtask

  // Long receiver hold-off so the input stalls, then a full drain pause
  task automatic test_backpressure();
    set_idling(0, 0);
    configure(64'd8, CFG_DATA_W'(rand_table(1'b1)));
    rx_hold_req = 300;
    send_random(40);
    wait_drain();
    send_random(20);
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    cur_limit   = PREFIX_LIMIT_RST;
    cur_table   = '0;
    mismatches  = 0;
    rx_hold_req = 0;
    set_idling(22, 59);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_fields();
    test_random_phases();
    test_backpressure();

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
